@@ hdl/assert_macros.svh @@
// Concurrent assertion helpers shared by the walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define PTW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check on every clock edge, reset included.
`define PTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PTW_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ hdl/ptw_pkg.sv @@
`default_nettype none

package ptw_pkg;

    localparam int PHYS_ADDR_BITS = 48;
    localparam int ADDR_W         = 48;
    localparam int DESC_W         = 64;
    localparam int VA_BITS_W      = 6;
    localparam int CFG_IDX_W      = 1;
    localparam int IDX_W          = 9;
    localparam int PAGE_BITS      = 12;
    localparam int OA_HI = ((PHYS_ADDR_BITS < ADDR_W) ? PHYS_ADDR_BITS : ADDR_W) - 1;

    localparam logic [VA_BITS_W-1:0] MIN_VA_BITS   = 6'd39;
    localparam logic [VA_BITS_W-1:0] MAX_VA_BITS   = 6'd48;
    localparam logic [VA_BITS_W-1:0] RESET_VA_BITS = 6'd48;

    localparam logic [1:0] LEVEL_ZERO = 2'd0;
    localparam logic [1:0] LEVEL_ONE  = 2'd1;
    localparam logic [1:0] LEVEL_LAST = 2'd3;

    localparam int DESC_VALID_BIT = 0;
    localparam int DESC_TABLE_BIT = 1;

    typedef enum logic {
        REQ_TRANSLATE = 1'b0,
        REQ_RESPONSE  = 1'b1
    } req_type_t;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FAULT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT    = 1'b0,
        CFG_VA_BITS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] vaddr;
        logic [DESC_W-1:0] descriptor;
    } ptw_item_t;

    typedef struct packed {
        result_kind_t      result_kind;
        logic [ADDR_W-1:0] read_address;
        logic [ADDR_W-1:0] physical_address;
        status_t           status;
    } ptw_result_t;

    // Low VA bit of the index for a level: 39, 30, 21, 12.
    function automatic logic [VA_BITS_W-1:0] level_shift(input logic [1:0] lvl);
        logic [VA_BITS_W-1:0] sh;
        unique case (lvl)
            2'd0:    sh = 6'd39;
            2'd1:    sh = 6'd30;
            2'd2:    sh = 6'd21;
            default: sh = 6'd12;
        endcase
        return sh;
    endfunction

    function automatic logic [IDX_W-1:0] index_of(input logic [ADDR_W-1:0] va,
                                                  input logic [1:0] lvl);
        logic [ADDR_W-1:0] shifted;
        shifted = va >> level_shift(lvl);
        return shifted[IDX_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] span_mask(input logic [1:0] lvl);
        logic [ADDR_W-1:0] one;
        one = {{(ADDR_W-1){1'b0}}, 1'b1};
        return (one << level_shift(lvl)) - one;
    endfunction

    // Table base with page offset dropped, plus index times eight.
    function automatic logic [ADDR_W-1:0] entry_address(input logic [ADDR_W-1:0] base,
                                                       input logic [IDX_W-1:0] idx);
        return {base[ADDR_W-1:PAGE_BITS], idx, 3'b000};
    endfunction

endpackage

`default_nettype wire

@@ hdl/ptw_in_reg.sv @@
`default_nettype none
`include "assert_macros.svh"

module ptw_in_reg
    import ptw_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ptw_item_t s_item,
    input  wire logic      advance,
    output logic           item_valid,
    output ptw_item_t      item
);

    logic      vld_reg;
    logic      vld_next;
    ptw_item_t item_reg;

    assign s_ready    = !vld_reg || advance;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_ready) begin
            vld_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    `PTW_ASSERT(a_stall_only_when_full, aclk, aresetn, !s_ready |-> vld_reg, "input stalled while empty")
    `PTW_ASSERT(a_advance_needs_word, aclk, aresetn, advance |-> vld_reg, "advance without a word")

endmodule

`default_nettype wire

@@ hdl/ptw_step.sv @@
`default_nettype none

module ptw_step
    import ptw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [ADDR_W-1:0]    root_table_address,
    input  wire logic [VA_BITS_W-1:0] va_bits,
    input  wire ptw_item_t            item,
    input  wire logic                 fire,
    output logic                      result_valid,
    output ptw_result_t               result,
    output logic                      walk_busy
);

    logic              busy_reg;
    logic              busy_next;
    logic [1:0]        level_reg;
    logic [1:0]        level_next;
    logic [ADDR_W-1:0] saved_reg;
    logic [ADDR_W-1:0] saved_next;

    logic              va_bad;
    logic [1:0]        entry_level;
    logic [ADDR_W-1:0] oa;
    logic [ADDR_W-1:0] va_high;

    assign walk_busy = busy_reg;

    always_comb begin
        va_high     = item.vaddr >> va_bits;
        va_bad      = (va_bits < MIN_VA_BITS) || (va_bits > MAX_VA_BITS) || (va_high != '0);
        entry_level = (va_bits == MIN_VA_BITS) ? LEVEL_ONE : LEVEL_ZERO;
        oa          = '0;
        oa[OA_HI:PAGE_BITS] = item.descriptor[OA_HI:PAGE_BITS];
    end

    always_comb begin
        busy_next    = busy_reg;
        level_next   = level_reg;
        saved_next   = saved_reg;
        result_valid = 1'b0;
        result       = '0;
        unique case (req_type_t'(item.req_type))
            REQ_TRANSLATE: begin
                // A new request drops any walk in flight.
                result_valid = 1'b1;
                busy_next    = 1'b0;
                if (va_bad) begin
                    result.result_kind = KIND_DONE;
                    result.status      = STATUS_RANGE;
                end else begin
                    busy_next           = 1'b1;
                    level_next          = entry_level;
                    saved_next          = item.vaddr;
                    result.result_kind  = KIND_READ;
                    result.read_address = entry_address(root_table_address,
                        index_of(item.vaddr, entry_level));
                end
            end
            REQ_RESPONSE: begin
                if (busy_reg) begin
                    result_valid = 1'b1;
                    if (!item.descriptor[DESC_VALID_BIT]) begin
                        busy_next          = 1'b0;
                        result.result_kind = KIND_DONE;
                        result.status      = STATUS_FAULT;
                    end else if (level_reg == LEVEL_LAST || !item.descriptor[DESC_TABLE_BIT]) begin
                        busy_next               = 1'b0;
                        result.result_kind      = KIND_DONE;
                        result.physical_address = oa + (saved_reg & span_mask(level_reg));
                    end else begin
                        level_next          = level_reg + 2'd1;
                        result.result_kind  = KIND_READ;
                        result.read_address = entry_address(oa,
                            index_of(saved_reg, level_next));
                    end
                end
            end
            default: begin
                result_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            level_reg <= LEVEL_ZERO;
            saved_reg <= '0;
        end else if (fire) begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            saved_reg <= saved_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ptw_out_reg.sv @@
`default_nettype none

module ptw_out_reg
    import ptw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire logic        load_valid,
    input  wire ptw_result_t load_result,
    output logic             out_free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output ptw_result_t      m_result
);

    logic        vld_reg;
    logic        vld_next;
    ptw_result_t res_reg;

    assign out_free = !vld_reg || m_ready;
    assign m_valid  = vld_reg;
    assign m_result = res_reg;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = load_valid;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            res_reg <= load_result;
        end
    end

endmodule

`default_nettype wire

@@ hdl/page_table_walker.sv @@
// Page table walker, 4 KiB granule, tables held in external memory.
// Input channel (s_*): a translate request (s_req_type 0, s_vaddr)
// or a descriptor word returned from memory (s_req_type 1, s_descriptor).
// Result channel (m_*): a descriptor read request (m_result_kind 0,
// m_read_address) or a finished translation (m_result_kind 1,
// m_physical_address, m_status). Each input word gives at most one result;
// a descriptor word that arrives with no walk open gives none.
// Configuration (cfg_*): index 0 is the root table base, index 1 the VA
// width; write only while no walk is open. cfg_ready is always high.
// An accepted word waits in the input register; its result is registered in
// the output register for m_*. Throughput: one word per cycle while m_ready
// is high, set by the single combinational step between the two registers.
// The input register takes a new word while a result waits in the output
// register; a stalled m_ready backs up into s_ready once both are full.
// Reset clears the walk state, sets the root base to zero and the VA
// width to 48, and empties both registers.
`default_nettype none
`include "assert_macros.svh"

module page_table_walker
    import ptw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_req_type,
    input  wire logic [ADDR_W-1:0]    s_vaddr,
    input  wire logic [DESC_W-1:0]    s_descriptor,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_result_kind,
    output logic [ADDR_W-1:0]         m_read_address,
    output logic [ADDR_W-1:0]         m_physical_address,
    output logic [1:0]                m_status
);

    logic [ADDR_W-1:0]    root_reg;
    logic [VA_BITS_W-1:0] va_bits_reg;

    ptw_item_t   s_item;
    ptw_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        out_free;
    logic        step_valid;
    ptw_result_t step_result;
    ptw_result_t m_result;
    logic        walk_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= '0;
            va_bits_reg <= RESET_VA_BITS;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROOT:    root_reg    <= cfg_data;
                CFG_VA_BITS: va_bits_reg <= cfg_data[VA_BITS_W-1:0];
                default:     root_reg    <= root_reg;
            endcase
        end
    end

    assign s_item.req_type   = s_req_type;
    assign s_item.vaddr      = s_vaddr;
    assign s_item.descriptor = s_descriptor;

    // Move the word on only when the result register can take its result.
    assign advance = item_valid && out_free;

    ptw_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ptw_step u_step (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .root_table_address (root_reg),
        .va_bits            (va_bits_reg),
        .item               (item),
        .fire               (advance),
        .result_valid       (step_valid),
        .result             (step_result),
        .walk_busy          (walk_busy)
    );

    ptw_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .load_valid  (step_valid),
        .load_result (step_result),
        .out_free    (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    assign m_result_kind      = m_result.result_kind;
    assign m_read_address     = m_result.read_address;
    assign m_physical_address = m_result.physical_address;
    assign m_status           = m_result.status;

    `PTW_ASSERT(a_read_keeps_walk_open, aclk, aresetn, m_valid && m_result_kind == KIND_READ |-> walk_busy, "read request out but no walk open")
    `PTW_ASSERT(a_done_has_no_raddr, aclk, aresetn, m_valid && m_result_kind == KIND_DONE |-> m_read_address == '0, "finished result carries a read address")
    `PTW_ASSERT(a_fault_has_no_pa, aclk, aresetn, m_valid && m_status != STATUS_OK |-> m_physical_address == '0 && m_result_kind == KIND_DONE, "failed result carries an address")
    `PTW_ASSERT_ALWAYS(a_reset_empties, aclk, !$past(aresetn) |-> !m_valid && !walk_busy, "state not cleared by reset")

endmodule

`default_nettype wire

@@ test/tb_page_table_walker.sv @@
`timescale 1ns / 1ps

module tb_page_table_walker;
    import ptw_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [ADDR_W-1:0] OA_MASK =
        ADDR_W'(((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'hFFF);

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROOT;
    logic [ADDR_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = REQ_TRANSLATE;
    logic [ADDR_W-1:0]    s_vaddr = '0;
    logic [DESC_W-1:0]    s_descriptor = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_result_kind;
    logic [ADDR_W-1:0]    m_read_address;
    logic [ADDR_W-1:0]    m_physical_address;
    logic [1:0]           m_status;

    page_table_walker uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_vaddr            (s_vaddr),
        .s_descriptor       (s_descriptor),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_read_address     (m_read_address),
        .m_physical_address (m_physical_address),
        .m_status           (m_status)
    );

    always #1 aclk = ~aclk;

    ptw_item_t   pending_words[$];
    ptw_result_t walk_outputs_due[$];
    ptw_item_t   next_word;
    ptw_item_t   taken_word;
    ptw_result_t predicted, oldest_due;

    // walker copy kept in step with the block
    logic [ADDR_W-1:0]    tb_root_base = '0;
    logic [VA_BITS_W-1:0] tb_va_width = RESET_VA_BITS;
    logic                 walk_open = 1'b0;
    logic [1:0]           walk_depth = LEVEL_ZERO;
    logic [ADDR_W-1:0]    walk_va = '0;

    logic [VA_BITS_W-1:0] gen_va_width = RESET_VA_BITS;
    int   error_count = 0;
    int   cycle_count = 0;
    bit   s_accepted = 1'b0;
    bit   tx_gaps = 1'b0;
    bit   rx_stalls = 1'b0;
    bit   long_hold = 1'b0;
    bit   hold_go = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;
    int   rx_run = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [VA_BITS_W-1:0] index_lsb(input logic [1:0] lvl);
        return 6'd39 - 6'd9 * {4'd0, lvl};
    endfunction

    function automatic logic [ADDR_W-1:0] table_entry(input logic [ADDR_W-1:0] base,
                                                      input logic [ADDR_W-1:0] va,
                                                      input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(va >> index_lsb(lvl));
        return (base & ~48'hFFF) + {36'd0, idx, 3'd0};
    endfunction

    function automatic bit predict_walk_step(input ptw_item_t w, output ptw_result_t r);
        logic [ADDR_W-1:0] oa;
        r = '0;
        if (w.req_type == REQ_TRANSLATE) begin
            walk_open = 1'b0;
            if (tb_va_width < MIN_VA_BITS || tb_va_width > MAX_VA_BITS ||
                (w.vaddr >> tb_va_width) != '0) begin
                r.result_kind = KIND_DONE;
                r.status = STATUS_RANGE;
                return 1'b1;
            end
            walk_open = 1'b1;
            walk_depth = 2'(4 - (int'(tb_va_width) - 4) / 9);
            walk_va = w.vaddr;
            r.read_address = table_entry(tb_root_base, walk_va, walk_depth);
            return 1'b1;
        end
        // a descriptor word with no walk open is dropped
        if (!walk_open)
            return 1'b0;
        if (!w.descriptor[DESC_VALID_BIT]) begin
            walk_open = 1'b0;
            r.result_kind = KIND_DONE;
            r.status = STATUS_FAULT;
            return 1'b1;
        end
        oa = w.descriptor[ADDR_W-1:0] & OA_MASK;
        if (walk_depth == LEVEL_LAST || !w.descriptor[DESC_TABLE_BIT]) begin
            walk_open = 1'b0;
            r.result_kind = KIND_DONE;
            r.physical_address = oa + (walk_va & ((48'd1 << index_lsb(walk_depth)) - 48'd1));
            return 1'b1;
        end
        walk_depth = walk_depth + 2'd1;
        r.read_address = table_entry(oa, walk_va, walk_depth);
        return 1'b1;
    endfunction

    // sender: bursts of words, with random gaps in between when tx_gaps is set
    always @(negedge aclk) begin
        if (s_valid && !s_accepted) begin
            // hold the word until it is taken
        end else if (tx_gaps && gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            s_valid <= 1'b1;
            s_req_type <= next_word.req_type;
            s_vaddr <= next_word.vaddr;
            s_descriptor <= next_word.descriptor;
            if (tx_gaps) begin
                if (burst_left == 0) begin
                    gap_left = $urandom_range(1, 8);
                    burst_left = $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: ready and stall runs of random length when rx_stalls is set, held off during long_hold
    always @(negedge aclk) begin
        if (long_hold) begin
            m_ready <= 1'b0;
        end else if (!rx_stalls) begin
            m_ready <= 1'b1;
        end else if (rx_run > 0) begin
            rx_run--;
        end else begin
            m_ready <= !m_ready;
            rx_run = m_ready ? $urandom_range(0, 4) : $urandom_range(0, 6);
        end
    end

    always @(posedge aclk) begin
        s_accepted <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ROOT)
                    tb_root_base = cfg_data;
                else
                    tb_va_width = cfg_data[VA_BITS_W-1:0];
            end
            if (s_valid && s_ready) begin
                taken_word.req_type = s_req_type;
                taken_word.vaddr = s_vaddr;
                taken_word.descriptor = s_descriptor;
                if (predict_walk_step(taken_word, predicted))
                    walk_outputs_due.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (walk_outputs_due.size() == 0) begin
                    report_mismatch("result with nothing due", 64'(m_read_address),
                                    64'(m_physical_address));
                end else begin
                    oldest_due = walk_outputs_due.pop_front();
                    if (m_result_kind !== oldest_due.result_kind)
                        report_mismatch("result_kind", 64'(m_result_kind),
                                        64'(oldest_due.result_kind));
                    if (m_read_address !== oldest_due.read_address)
                        report_mismatch("read_address", 64'(m_read_address),
                                        64'(oldest_due.read_address));
                    if (m_physical_address !== oldest_due.physical_address)
                        report_mismatch("physical_address", 64'(m_physical_address),
                                        64'(oldest_due.physical_address));
                    if (m_status !== oldest_due.status)
                        report_mismatch("status", 64'(m_status), 64'(oldest_due.status));
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (hold_go);
        @(posedge aclk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        long_hold = 1'b0;
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_translate(input logic [ADDR_W-1:0] va);
        ptw_item_t w;
        w.req_type = REQ_TRANSLATE;
        w.vaddr = va;
        w.descriptor = rand64();
        pending_words.push_back(w);
    endtask

    task automatic push_response(input logic [DESC_W-1:0] d);
        ptw_item_t w;
        w.req_type = REQ_RESPONSE;
        w.vaddr = rand48();
        w.descriptor = d;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [ADDR_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_VA_BITS)
            gen_va_width = value[VA_BITS_W-1:0];
    endtask

    // wait until every word is taken and every result is back
    task automatic drain();
        int n;
        n = 0;
        @(posedge aclk);
        while (pending_words.size() != 0 || s_valid) @(posedge aclk);
        @(negedge aclk);
        while (walk_outputs_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge aclk);
            n++;
        end
        if (walk_outputs_due.size() != 0) begin
            report_mismatch("results never arrived", 64'(walk_outputs_due.size()), 64'd0);
            walk_outputs_due.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // a well-formed walk: translate, then tables down to a leaf or a fault
    task automatic queue_walk(output int words);
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] lim;
        logic [DESC_W-1:0] d;
        int lvl;
        int pick;
        lim = (48'd1 << gen_va_width) - 48'd1;
        case ($urandom_range(0, 7))
            0:       va = '0;
            1:       va = lim;
            default: va = rand48() & lim;
        endcase
        push_translate(va);
        words = 1;
        for (lvl = (gen_va_width == MIN_VA_BITS) ? 1 : 0; lvl <= 3; lvl++) begin
            d = rand64();
            pick = $urandom_range(0, 9);
            words++;
            if (pick == 0) begin
                d[DESC_VALID_BIT] = 1'b0;
                push_response(d);
                break;
            end
            d[DESC_VALID_BIT] = 1'b1;
            if (lvl == 3 || pick >= 7) begin
                if (lvl < 3)
                    d[DESC_TABLE_BIT] = 1'b0;
                push_response(d);
                break;
            end
            d[DESC_TABLE_BIT] = 1'b1;
            push_response(d);
        end
    endtask

    task automatic run_phase(input int vb, input logic [ADDR_W-1:0] root, input int quota,
                             input bit gaps, input bit stalls);
        logic [ADDR_W-1:0] cfg_word;
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] lim;
        int counted;
        int pick;
        int n;
        int bit_pos;
        drain();
        cfg_word = rand48();
        cfg_word[VA_BITS_W-1:0] = VA_BITS_W'(vb);
        write_reg(CFG_VA_BITS, cfg_word);
        write_reg(CFG_ROOT, root);
        @(posedge aclk);
        tx_gaps = gaps;
        rx_stalls = stalls;
        lim = (48'd1 << gen_va_width) - 48'd1;
        counted = 0;
        while (counted < quota) begin
            pick = $urandom_range(0, 99);
            if (gen_va_width < MIN_VA_BITS || gen_va_width > MAX_VA_BITS) begin
                if (pick < 60) begin
                    push_translate(rand48());
                    counted++;
                end else begin
                    push_response(rand64());
                end
            end else if (pick < 75) begin
                queue_walk(n);
                counted += n;
            end else if (pick < 85) begin
                // open a walk and drop it partway down
                push_translate(rand48() & lim);
                counted++;
                repeat ($urandom_range(0, 2)) begin
                    push_response(rand64() | 64'h3);
                    counted++;
                end
            end else if (pick < 93) begin
                push_response(rand64());
            end else begin
                va = rand48();
                if (gen_va_width < MAX_VA_BITS) begin
                    bit_pos = $urandom_range(int'(gen_va_width), ADDR_W - 1);
                    va[bit_pos] = 1'b1;
                end
                push_translate(va);
                counted++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: root zero, 48-bit VA
        push_response(64'hFFFF_FFFF_FFFF_FFFF);
        push_translate(48'h0);
        push_response(64'hFFFF_FFFF_FFFF_FFFF);
        push_response(64'hFFFF_FFFF_FFFF_FFFF);
        push_response(64'hFFFF_FFFF_FFFF_FFFF);
        push_response(64'hFFFF_FFFF_FFFF_FFFF);
        push_translate(48'hFFFF_FFFF_FFFF);
        push_response(64'h0000_8000_0000_0001);
        push_translate(48'h1234_5678_9ABC);
        push_response(64'hFFFF_FFFF_FFFF_FFFE);
        push_translate(48'h0000_4020_1008);
        push_translate(48'h7FFF_FFFF_F000);
        push_response(64'h0000_0000_0000_0003);
        push_response(64'h0000_ABCD_E000_0001);
        push_response(64'h0);
        drain();
        write_reg(CFG_VA_BITS, 48'd39);
        write_reg(CFG_ROOT, 48'h0000_1234_5FFF);
        @(posedge aclk);
        push_translate(48'h0080_0000_0000);
        push_translate(48'h007F_FFFF_FFFF);
        push_response(64'h8000_0000_0000_0003);
        push_response(64'h8000_0000_0000_0003);
        push_response(64'h0000_0000_0000_0001);
        push_translate(48'hFFFF_FFFF_FFFF);
        drain();
        write_reg(CFG_VA_BITS, 48'd50);
        @(posedge aclk);
        push_translate(48'h0);
        push_response(64'h3);

        run_phase(48, 48'hFFFF_FFFF_FFFF, 120, 1'b0, 1'b0);
        run_phase(39, 48'h0, 120, 1'b1, 1'b1);
        run_phase(40, rand48(), 120, 1'b1, 1'b1);
        hold_go = 1'b1;
        run_phase(38, rand48(), 20, 1'b1, 1'b1);
        run_phase(47, rand48(), 120, 1'b1, 1'b0);
        run_phase(0, rand48(), 20, 1'b1, 1'b1);
        run_phase(44, rand48(), 120, 1'b0, 1'b1);
        run_phase(63, rand48(), 20, 1'b1, 1'b1);
        run_phase(49, rand48(), 20, 1'b0, 1'b0);
        run_phase(43, rand48(), 120, 1'b1, 1'b1);
        run_phase(48, rand48(), 120, 1'b1, 1'b1);
        drain();
        repeat (8) @(posedge aclk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
